[src/sse_pkg.sv]
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types for the selection sort engine: data word and controller states.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SWAPA = 5'b00100,
        ST_SWAPB = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

endpackage

[src/sse_in_if.sv]
// ----------------------------------------------------------------------------
// sse_in_if
// Element request channel: one signed value per request, last marks run end.
// ----------------------------------------------------------------------------
interface sse_in_if import sse_pkg::*; ();

    logic  valid;
    logic  ready;
    word_t value;
    logic  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface

[src/sse_out_if.sv]
// ----------------------------------------------------------------------------
// sse_out_if
// Sorted result channel: one value per request with end-of-run and overflow.
// ----------------------------------------------------------------------------
interface sse_out_if import sse_pkg::*; ();

    logic  valid;
    logic  ready;
    word_t value_res;
    logic  last_res;
    logic  overflow;

    modport source (output valid, output value_res, output last_res, output overflow,
                    input ready);
    modport sink   (input valid, input value_res, input last_res, input overflow,
                    output ready);

endinterface

[src/sse_ram.sv]
// ----------------------------------------------------------------------------
// sse_ram
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sse_ram import sse_pkg::*; #(
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output word_t         rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  word_t         wr_data
);

    word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/selection_sort_engine.sv]
// ----------------------------------------------------------------------------
// selection_sort_engine
// Buffers a run of signed words, sorts it in place and streams it out.
// ----------------------------------------------------------------------------
// Usage:
//   elements : one signed 32-bit value per request; last ends the run. Taken
//              one per cycle while loading. Requests beyond DEPTH are dropped
//              and every result of that run then carries overflow.
//   sorted   : the run in ascending order, last_res on the final value.
// Phases, for a run of n stored values:
//   load  : each request is written to the store as it is taken.
//   sort  : pass f reads n-f entries through the single read port of the
//           store, retires the last read, then swaps through its write
//           port (the front entry to the minimum's slot, then the minimum
//           to the front); no sort for n = 1.
//   emit  : store read, then output register, per result; reads wait while
//           sorted.ready is low; the output register holds its value.
// elements.ready is high only while loading; a new run may load while the
// final result still waits in the output register. No clearing pass: reset
// returns straight to loading with an empty run and the overflow flag clear.
// ----------------------------------------------------------------------------
module selection_sort_engine import sse_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    sse_in_if.sink       elements,
    sse_out_if.source    sorted
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t        state_reg,   state_next;
    logic [CW-1:0] count_reg,   count_next;
    logic          dropped_reg, dropped_next;
    logic [AW-1:0] front_reg,   front_next;
    logic [CW-1:0] probe_reg,   probe_next;
    logic [CW-1:0] emit_reg,    emit_next;
    logic          pend_reg,    pend_next;
    logic [AW-1:0] rdq_reg,     rdq_next;
    logic [AW-1:0] pick_reg,    pick_next;
    word_t         min_reg,     min_next;
    word_t         fval_reg,    fval_next;
    logic          ovld_reg,    ovld_next;
    word_t         oval_reg,    oval_next;
    logic          olast_reg,   olast_next;
    logic          oovf_reg,    oovf_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    word_t         rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    word_t         wr_data;

    sse_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign elements.ready   = (state_reg == ST_LOAD);
    assign sorted.valid     = ovld_reg;
    assign sorted.value_res = oval_reg;
    assign sorted.last_res  = olast_reg;
    assign sorted.overflow  = oovf_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        front_next   = front_reg;
        probe_next   = probe_reg;
        emit_next    = emit_reg;
        pend_next    = 1'b0;
        rdq_next     = rdq_reg;
        pick_next    = pick_reg;
        min_next     = min_reg;
        fval_next    = fval_reg;
        ovld_next    = ovld_reg && !sorted.ready;
        oval_next    = oval_reg;
        olast_next   = olast_reg;
        oovf_next    = oovf_reg;
        rd_en        = 1'b0;
        rd_addr      = probe_reg[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = count_reg[AW-1:0];
        wr_data      = elements.value;

        case (state_reg)
            ST_LOAD:
            begin
                if (elements.valid)
                begin
                    if (count_reg < CW'(DEPTH))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (elements.last)
                    begin
                        front_next = '0;
                        probe_next = '0;
                        emit_next  = '0;
                        if (count_next >= CW'(2))
                        begin
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle across the unsorted tail
                if (probe_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = probe_reg[AW-1:0];
                    pend_next  = 1'b1;
                    rdq_next   = probe_reg[AW-1:0];
                    probe_next = probe_reg + 1'b1;
                end
                // the head of the tail seeds the minimum; strict less keeps the first one
                if (pend_reg)
                begin
                    if (rdq_reg == front_reg)
                    begin
                        min_next  = rd_data;
                        pick_next = front_reg;
                        fval_next = rd_data;
                    end
                    else if (rd_data < min_reg)
                    begin
                        min_next  = rd_data;
                        pick_next = rdq_reg;
                    end
                end
                if ((probe_reg == count_reg) && !pend_reg)
                begin
                    state_next = ST_SWAPA;
                end
            end

            ST_SWAPA:
            begin
                wr_en      = 1'b1;
                wr_addr    = pick_reg;
                wr_data    = fval_reg;
                state_next = ST_SWAPB;
            end

            ST_SWAPB:
            begin
                // the minimum lands last, so a self-swap leaves the entry intact
                wr_en      = 1'b1;
                wr_addr    = front_reg;
                wr_data    = min_reg;
                front_next = front_reg + 1'b1;
                probe_next = CW'(front_reg) + 1'b1;
                if ((CW'(front_reg) + CW'(2)) < count_reg)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // read only when the output register is free by the time data returns
                if ((emit_reg < count_reg) && !pend_reg && (!ovld_reg || sorted.ready))
                begin
                    rd_en     = 1'b1;
                    rd_addr   = emit_reg[AW-1:0];
                    pend_next = 1'b1;
                    rdq_next  = emit_reg[AW-1:0];
                    emit_next = emit_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    ovld_next  = 1'b1;
                    oval_next  = rd_data;
                    olast_next = ((CW'(rdq_reg) + 1'b1) == count_reg);
                    oovf_next  = dropped_reg;
                end
                if ((emit_reg == count_reg) && !pend_reg)
                begin
                    state_next   = ST_LOAD;
                    count_next   = '0;
                    dropped_next = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            front_reg   <= '0;
            probe_reg   <= '0;
            emit_reg    <= '0;
            pend_reg    <= 1'b0;
            rdq_reg     <= '0;
            pick_reg    <= '0;
            ovld_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            front_reg   <= front_next;
            probe_reg   <= probe_next;
            emit_reg    <= emit_next;
            pend_reg    <= pend_next;
            rdq_reg     <= rdq_next;
            pick_reg    <= pick_next;
            ovld_reg    <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg   <= min_next;
        fval_reg  <= fval_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
        oovf_reg  <= oovf_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond store depth");

    a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAPA) |-> ((pick_reg >= front_reg) && (CW'(pick_reg) < count_reg)))
        else $error("selected minimum outside unsorted tail");

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && pend_reg) |=> sorted.valid)
        else $error("store read in emit did not reach output register");

    a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && !pend_reg && (emit_reg == count_reg))
        |=> ((state_reg == ST_LOAD) && (count_reg == '0) && !dropped_reg))
        else $error("run not cleared after final result");

endmodule

[tb/sv/selection_sort_engine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selection_sort_engine_tb
// Feeds runs of signed words into the sort engine and checks every sorted
// result against a predictor of its own. The predictor sorts each run
// selection-wise and flags overflow when a run exceeds the store depth.
// Directed edge cases come first, then random runs under several idling
// mixes, a long result hold-off and a run that overfills the store.
// ----------------------------------------------------------------------------
module selection_sort_engine_tb;
    import sse_pkg::*;

    localparam int SORT_DEPTH     = 64;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int STALL_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_ITEMS    = 4;

    localparam word_t WORD_MIN = 32'sh8000_0000;
    localparam word_t WORD_MAX = 32'sh7fff_ffff;

    typedef struct {
        word_t value;
        logic  last;
    } element_req_t;

    typedef struct {
        word_t value_res;
        logic  last_res;
        logic  overflow;
    } sorted_word_t;

    logic clk = 1'b0;
    logic rst_n;

    sse_in_if  elements ();
    sse_out_if sorted ();

    selection_sort_engine #(
        .DEPTH (SORT_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .elements (elements),
        .sorted   (sorted)
    );

    always #CLK_HALF clk = ~clk;

    element_req_t element_backlog[$];
    sorted_word_t sorted_due[$];

    // run currently being collected by the predictor
    word_t run_values[SORT_DEPTH];
    int    run_count   = 0;
    logic  run_dropped = 1'b0;

    int requests_queued    = 0;
    int requests_taken     = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int holdoff_arm        = 0;
    int holdoff_seen       = 0;
    int stall_left         = 0;
    int idle_cycles        = 0;
    int error_count        = 0;

    task automatic sort_run_ascending();
        int    front;
        int    probe;
        int    pick;
        word_t held;
        for (front = 0; front + 1 < run_count; front++)
        begin
            pick = front;
            for (probe = front + 1; probe < run_count; probe++)
            begin
                if (run_values[probe] < run_values[pick])
                    pick = probe;
            end
            held              = run_values[pick];
            run_values[pick]  = run_values[front];
            run_values[front] = held;
        end
    endtask

    task automatic take_element(input word_t v, input logic is_last);
        sorted_word_t entry;
        if (run_count < SORT_DEPTH)
        begin
            run_values[run_count] = v;
            run_count++;
        end
        else
            run_dropped = 1'b1;
        if (is_last)
        begin
            sort_run_ascending();
            for (int k = 0; k < run_count; k++)
            begin
                entry.value_res = run_values[k];
                entry.last_res  = (k + 1 == run_count);
                entry.overflow  = run_dropped;
                sorted_due.push_back(entry);
            end
            run_count   = 0;
            run_dropped = 1'b0;
        end
    endtask

    function automatic word_t random_word();
        case ($urandom_range(0, 7))
            0:       random_word = WORD_MIN;
            1:       random_word = WORD_MAX;
            2, 3:    random_word = $signed($urandom_range(0, 15)) - 8;
            default: random_word = $urandom;
        endcase
    endfunction

    task automatic queue_word(input word_t v, input logic is_last);
        element_req_t req;
        req.value = v;
        req.last  = is_last;
        element_backlog.push_back(req);
        requests_queued++;
    endtask

    task automatic queue_run(input int n);
        for (int k = 0; k < n; k++)
            queue_word(random_word(), k == n - 1);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct    <= sender_pct;
        receiver_stall_pct <= receiver_pct;
    endtask

    // wait until every request is in and every result is out
    task automatic wait_drained();
        while (requests_taken != requests_queued || sorted_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_phase(input int sender_pct, input int receiver_pct);
        int count;
        int n;
        set_idling(sender_pct, receiver_pct);
        count = 0;
        while (count < PHASE_ITEMS)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            queue_run(n);
            count += n;
        end
        wait_drained();
    endtask

    // element driver
    always @(posedge clk or negedge rst_n)
    begin : drive_elements
        element_req_t next_req;
        if (!rst_n)
        begin
            elements.valid <= 1'b0;
            elements.value <= '0;
            elements.last  <= 1'b0;
        end
        else
        begin
            if (elements.valid && elements.ready)
            begin
                take_element(elements.value, elements.last);
                requests_taken <= requests_taken + 1;
            end
            if (!elements.valid || elements.ready)
            begin
                if (element_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    next_req = element_backlog.pop_front();
                    elements.valid <= 1'b1;
                    elements.value <= next_req.value;
                    elements.last  <= next_req.last;
                end
                else
                    elements.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : check_sorted
        sorted_word_t want;
        if (!rst_n)
            sorted.ready <= 1'b0;
        else
        begin
            if (sorted.valid && sorted.ready)
            begin
                if (sorted_due.size() == 0)
                begin
                    $display("%0t: unexpected result value=%0d last=%0b overflow=%0b",
                             $time, sorted.value_res, sorted.last_res, sorted.overflow);
                    error_count++;
                end
                else
                begin
                    want = sorted_due.pop_front();
                    if (sorted.value_res !== want.value_res)
                    begin
                        $display("%0t: value_res expected %0d actual %0d",
                                 $time, want.value_res, sorted.value_res);
                        error_count++;
                    end
                    if (sorted.last_res !== want.last_res)
                    begin
                        $display("%0t: last_res expected %0b actual %0b",
                                 $time, want.last_res, sorted.last_res);
                        error_count++;
                    end
                    if (sorted.overflow !== want.overflow)
                    begin
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, want.overflow, sorted.overflow);
                        error_count++;
                    end
                end
            end
            if (holdoff_arm != holdoff_seen)
            begin
                holdoff_seen <= holdoff_arm;
                stall_left   <= HOLDOFF_CYCLES;
                sorted.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left   <= stall_left - 1;
                sorted.ready <= 1'b0;
            end
            else
                sorted.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // watchdog on cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((elements.valid && elements.ready) || (sorted.valid && sorted.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, mixed signs and a duplicate pair of extremes
        queue_word(WORD_MIN, 1'b0);
        queue_word(WORD_MAX, 1'b0);
        queue_word(0, 1'b0);
        queue_word(-1, 1'b0);
        queue_word(1, 1'b0);
        queue_word(WORD_MAX, 1'b0);
        queue_word(WORD_MIN, 1'b1);
        // single-element runs
        queue_word(WORD_MIN, 1'b1);
        queue_word(WORD_MAX, 1'b1);
        // equal values
        queue_word(5, 1'b0);
        queue_word(5, 1'b0);
        queue_word(-5, 1'b0);
        queue_word(5, 1'b1);
        // reverse order
        for (int k = 3; k >= -2; k--)
            queue_word(k, k == -2);
        // alternating bit patterns
        queue_word(32'sh5555_5555, 1'b0);
        queue_word(32'shAAAA_AAAA, 1'b1);
        wait_drained();

        random_phase(0, 0);
        random_phase(68, 0);
        random_phase(0, 68);
        random_phase(17, 17);

        // stall the result side long enough for a second run to back up at the input
        set_idling(0, 0);
        holdoff_arm <= holdoff_arm + 1;
        queue_run(6);
        queue_run(4);
        wait_drained();

        // overfill the store: the request after the full point and the last one are dropped
        set_idling(17, 17);
        queue_run(SORT_DEPTH + 2);
        queue_run(3);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
